>>> hdl/tam_pkg.sv
// Shared types, widths, register codes and the quarter-wave sine table
// for the tremolo amplitude modulator. No dependencies.
package tam_pkg;

	localparam int SAMPLE_W    = 24;
	localparam int PHASE_W     = 20;
	localparam int PERIOD_W    = PHASE_W + 1;
	localparam int TBL_AW      = 10;
	localparam int QTR_AW      = TBL_AW - 2;
	localparam int GAIN_W      = 17;
	localparam int DEPTH_W     = 7;
	localparam int PMS_W       = 13;
	localparam int SRATE_W     = 18;
	localparam int CHAN_W      = 4;
	localparam int CIDX_W      = 3;
	localparam int CFG_AW      = 2;
	localparam int CFG_DW      = 18;

	localparam int PER_NUM_W   = PMS_W + SRATE_W;
	localparam int PER_QUOT_W  = 22;
	localparam int PER_REM_W   = 10;
	localparam int PER_CNT_W   = 5;
	localparam int IDX_CNT_W   = 4;
	localparam int ATT_NUM_W   = 24;
	localparam int ATT_REM_W   = 8;
	localparam int GAIN_CNT_W  = 5;
	localparam int OFFS_W      = GAIN_W + 1;
	localparam int MUL_W       = SAMPLE_W + GAIN_W;
	localparam int SCALE_CNT_W = 5;

	localparam logic [PER_CNT_W-1:0]   PER_STEPS   = PER_CNT_W'(PER_NUM_W);
	localparam logic [IDX_CNT_W-1:0]   IDX_STEPS   = IDX_CNT_W'(TBL_AW);
	localparam logic [GAIN_CNT_W-1:0]  GAIN_STEPS  = GAIN_CNT_W'(ATT_NUM_W + 1);
	localparam logic [SCALE_CNT_W-1:0] SCALE_STEPS = SCALE_CNT_W'(GAIN_W + 1);

	localparam logic [PER_NUM_W-1:0]   MS_ROUND    = PER_NUM_W'(999);
	localparam logic [PER_REM_W:0]     MS_DIV      = (PER_REM_W+1)'(1000);
	localparam logic [PERIOD_W-1:0]    PERIOD_MAX  = PERIOD_W'(1) << PHASE_W;
	localparam logic [DEPTH_W-1:0]     DEPTH_MAX   = DEPTH_W'(100);
	localparam logic [ATT_NUM_W-1:0]   ATT_ROUND   = ATT_NUM_W'(100);
	localparam logic [ATT_REM_W:0]     ATT_DIV     = (ATT_REM_W+1)'(200);
	localparam logic [CHAN_W-1:0]      CHAN_MAX    = CHAN_W'(8);
	localparam logic [GAIN_W-1:0]      UNITY       = GAIN_W'(65536);
	localparam logic [MUL_W-1:0]       MUL_ROUND   = MUL_W'(32768);

	localparam logic [DEPTH_W-1:0] DEPTH_RST = DEPTH_W'(25);
	localparam logic [PMS_W-1:0]   PMS_RST   = PMS_W'(200);
	localparam logic [SRATE_W-1:0] SRATE_RST = SRATE_W'(48000);
	localparam logic [CHAN_W-1:0]  CHAN_RST  = CHAN_W'(1);

	typedef enum logic [CFG_AW-1:0] {
		CFG_DEPTH,
		CFG_PERIOD_MS,
		CFG_SAMPLE_RATE,
		CFG_CHANNELS
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PERIOD,
		ST_PREP,
		ST_INDEX,
		ST_GAIN,
		ST_SCALE,
		ST_HOLD
	} tam_state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} tam_sts_t;

	localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;

	function automatic logic [GAIN_W-1:0] sine_entry(input int r);
		longint unsigned rr;
		longint unsigned x;
		longint unsigned x2;
		longint unsigned t;
		longint s;
		rr = 64'(r) << 22;
		x  = (rr * PI_HALF_Q30) >> 30;
		x2 = (x * x) >> 30;
		t  = x;
		s  = longint'(x);
		t  = ((t * x2) >> 30) / 6;
		s  = s - longint'(t);
		t  = ((t * x2) >> 30) / 20;
		s  = s + longint'(t);
		t  = ((t * x2) >> 30) / 42;
		s  = s - longint'(t);
		t  = ((t * x2) >> 30) / 72;
		s  = s + longint'(t);
		t  = ((t * x2) >> 30) / 110;
		s  = s - longint'(t);
		if (s < 0) begin
			s = 0;
		end
		s = (s + 8192) >>> 14;
		if (s > 65536) begin
			s = 65536;
		end
		return GAIN_W'(s);
	endfunction

	typedef logic [GAIN_W-1:0] sine_qtr_t [0:(1<<QTR_AW)-1];

	function automatic sine_qtr_t sine_qtr_build();
		sine_qtr_t tbl;
		for (int i = 0; i < (1 << QTR_AW); i++) begin
			tbl[i] = sine_entry(i);
		end
		return tbl;
	endfunction

	localparam sine_qtr_t           SINE_QTR  = sine_qtr_build();
	localparam logic [GAIN_W-1:0]   SINE_PEAK = sine_entry(1 << QTR_AW);

endpackage

>>> hdl/tam_period.sv
// Period in frames: ceil(period_ms * sample_rate / 1000), clamped to [1, 2^20].
// Bit-serial restoring divide by 1000, one quotient bit a cycle. Uses tam_pkg.
module tam_period (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [tam_pkg::PMS_W-1:0]   period_ms,
	input  logic [tam_pkg::SRATE_W-1:0] sample_rate,
	output tam_pkg::tam_sts_t           sts,
	output logic [tam_pkg::PERIOD_W-1:0] period
);
	import tam_pkg::*;

	logic [PER_NUM_W-1:0]  num_q;
	logic [PER_REM_W-1:0]  rem_q;
	logic [PER_QUOT_W-1:0] quot_q;
	logic [PER_CNT_W-1:0]  cnt_q;
	logic                  done_q;
	logic [PER_NUM_W-1:0]  prod;
	logic [PER_REM_W:0]    rem2;
	logic                  ge;
	logic [PER_REM_W:0]    diff;

	assign prod = {{SRATE_W{1'b0}}, period_ms} * {{PMS_W{1'b0}}, sample_rate};
	assign rem2 = {rem_q, num_q[PER_NUM_W-1]};
	assign ge   = rem2 >= MS_DIV;
	assign diff = rem2 - MS_DIV;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= PER_STEPS;
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == PER_CNT_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= prod + MS_ROUND;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			num_q  <= num_q << 1;
			rem_q  <= ge ? diff[PER_REM_W-1:0] : rem2[PER_REM_W-1:0];
			quot_q <= {quot_q[PER_QUOT_W-2:0], ge};
		end
	end

	always_comb begin
		if (quot_q == '0) begin
			period = PERIOD_W'(1);
		end else if (quot_q > PER_QUOT_W'(PERIOD_MAX)) begin
			period = PERIOD_MAX;
		end else begin
			period = quot_q[PERIOD_W-1:0];
		end
	end

	assign sts.busy = cnt_q != '0;
	assign sts.done = done_q;

endmodule

>>> hdl/tam_index.sv
// Sine table index: floor(phase * 1024 / period), bit-serial restoring divide,
// one index bit a cycle. Uses tam_pkg.
module tam_index (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [tam_pkg::PHASE_W-1:0]  phase,
	input  logic [tam_pkg::PERIOD_W-1:0] period,
	output tam_pkg::tam_sts_t            sts,
	output logic [tam_pkg::TBL_AW-1:0]   index
);
	import tam_pkg::*;

	logic [PHASE_W-1:0]   rem_q;
	logic [TBL_AW-1:0]    k_q;
	logic [IDX_CNT_W-1:0] cnt_q;
	logic                 done_q;
	logic [PERIOD_W-1:0]  rem2;
	logic                 ge;
	logic [PERIOD_W-1:0]  diff;

	assign rem2 = {rem_q, 1'b0};
	assign ge   = rem2 >= period;
	assign diff = rem2 - period;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= IDX_STEPS;
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == IDX_CNT_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= phase;
		end else if (cnt_q != '0) begin
			rem_q <= ge ? diff[PHASE_W-1:0] : rem2[PHASE_W-1:0];
			k_q   <= {k_q[TBL_AW-2:0], ge};
		end
	end

	assign index    = k_q;
	assign sts.busy = cnt_q != '0;
	assign sts.done = done_q;

endmodule

>>> hdl/tam_gain.sv
// Gain from table index and depth: quarter-wave sine lookup, depth multiply,
// then a bit-serial divide by 200 for the attenuation. Uses tam_pkg.
module tam_gain (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [tam_pkg::TBL_AW-1:0]  index,
	input  logic [tam_pkg::DEPTH_W-1:0] depth,
	output tam_pkg::tam_sts_t           sts,
	output logic [tam_pkg::GAIN_W-1:0]  gain
);
	import tam_pkg::*;

	logic [GAIN_CNT_W-1:0] cnt_q;
	logic                  done_q;
	logic                  neg_q;
	logic [GAIN_W-1:0]     mag_q;
	logic [DEPTH_W-1:0]    depth_q;
	logic [ATT_NUM_W-1:0]  num_q;
	logic [ATT_REM_W-1:0]  rem_q;
	logic [GAIN_W-1:0]     quot_q;
	logic [QTR_AW-1:0]     pos;
	logic [GAIN_W-1:0]     mag;
	logic [OFFS_W-1:0]     offs;
	logic [ATT_NUM_W:0]    prod;
	logic [ATT_REM_W:0]    rem2;
	logic                  ge;
	logic [ATT_REM_W:0]    diff;

	assign pos = index[QTR_AW-1:0];

	always_comb begin
		if (!index[QTR_AW]) begin
			mag = SINE_QTR[pos];
		end else if (pos == '0) begin
			mag = SINE_PEAK;
		end else begin
			mag = SINE_QTR[QTR_AW'(-pos)];
		end
	end

	assign offs = neg_q ? ({1'b0, UNITY} - {1'b0, mag_q}) : ({1'b0, UNITY} + {1'b0, mag_q});
	assign prod = {{(OFFS_W){1'b0}}, depth_q} * {{DEPTH_W{1'b0}}, offs};
	assign rem2 = {rem_q, num_q[ATT_NUM_W-1]};
	assign ge   = rem2 >= ATT_DIV;
	assign diff = rem2 - ATT_DIV;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= GAIN_STEPS;
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == GAIN_CNT_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q   <= index[TBL_AW-1];
			mag_q   <= mag;
			depth_q <= (depth > DEPTH_MAX) ? DEPTH_MAX : depth;
		end else if (cnt_q == GAIN_STEPS) begin
			num_q <= prod[ATT_NUM_W-1:0] + ATT_ROUND;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			num_q  <= num_q << 1;
			rem_q  <= ge ? diff[ATT_REM_W-1:0] : rem2[ATT_REM_W-1:0];
			quot_q <= {quot_q[GAIN_W-2:0], ge};
		end
	end

	assign gain     = UNITY - quot_q;
	assign sts.busy = cnt_q != '0;
	assign sts.done = done_q;

	a_att_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> quot_q <= UNITY)
		else $error("attenuation above unity");

endmodule

>>> hdl/tam_scale.sv
// Sample times gain: MSB-first shift-add over the gain bits, then round
// half up and saturate to the sample width. Uses tam_pkg.
module tam_scale (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic signed [tam_pkg::SAMPLE_W-1:0] sample,
	input  logic [tam_pkg::GAIN_W-1:0]          gain,
	output tam_pkg::tam_sts_t                   sts,
	output logic signed [tam_pkg::SAMPLE_W-1:0] result
);
	import tam_pkg::*;

	logic [SCALE_CNT_W-1:0]     cnt_q;
	logic                       done_q;
	logic signed [SAMPLE_W-1:0] mcand_q;
	logic [GAIN_W-1:0]          gbits_q;
	logic signed [MUL_W-1:0]    acc_q;
	logic signed [SAMPLE_W-1:0] res_q;
	logic signed [MUL_W-1:0]    addend;
	logic signed [MUL_W-1:0]    rnd;
	logic signed [SAMPLE_W:0]   shifted;
	logic signed [SAMPLE_W-1:0] sat;

	assign addend  = gbits_q[GAIN_W-1] ? MUL_W'(mcand_q) : '0;
	assign rnd     = acc_q + MUL_ROUND;
	assign shifted = rnd[MUL_W-1:MUL_W-SAMPLE_W-1];

	always_comb begin
		if (shifted[SAMPLE_W] != shifted[SAMPLE_W-1]) begin
			sat = shifted[SAMPLE_W] ? {1'b1, {(SAMPLE_W-1){1'b0}}} : {1'b0, {(SAMPLE_W-1){1'b1}}};
		end else begin
			sat = shifted[SAMPLE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				cnt_q <= SCALE_STEPS;
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == SCALE_CNT_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mcand_q <= sample;
			gbits_q <= gain;
			acc_q   <= '0;
		end else if (cnt_q == SCALE_CNT_W'(1)) begin
			res_q <= sat;
		end else if (cnt_q != '0) begin
			acc_q   <= (acc_q <<< 1) + addend;
			gbits_q <= gbits_q << 1;
		end
	end

	assign result   = res_q;
	assign sts.busy = cnt_q != '0;
	assign sts.done = done_q;

endmodule

>>> hdl/tremolo_amplitude_modulator.sv
// Tremolo with a sine LFO: sequencer, config registers, phase and channel state.
// Each item runs through the index divide, the gain divide and the multiply in turn;
// src_stall holds off the next item until its result is loaded into sample_out.
// The first item after reset or after a write to period_ms or sample_rate also
// waits while the period in frames is rebuilt. Reset (arst_n low, asynchronous)
// restores register defaults, clears phase, channel index and output valid. Uses tam_pkg.
module tremolo_amplitude_modulator (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                src_valid,
	output logic                                src_stall,
	input  logic signed [tam_pkg::SAMPLE_W-1:0] sample_in,
	output logic                                dst_valid,
	input  logic                                dst_stall,
	output logic signed [tam_pkg::SAMPLE_W-1:0] sample_out,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [tam_pkg::CFG_AW-1:0]          cfg_index,
	input  logic [tam_pkg::CFG_DW-1:0]          cfg_data
);
	import tam_pkg::*;

	tam_state_t                 state_q;
	tam_state_t                 state_d;
	logic [DEPTH_W-1:0]         depth_q;
	logic [PMS_W-1:0]           pms_q;
	logic [SRATE_W-1:0]         srate_q;
	logic [CHAN_W-1:0]          chans_q;
	logic                       period_dirty_q;
	logic [PHASE_W-1:0]         phase_q;
	logic [CIDX_W-1:0]          chan_idx_q;
	logic signed [SAMPLE_W-1:0] sample_q;
	logic                       dst_valid_q;
	logic signed [SAMPLE_W-1:0] out_q;

	logic                       per_start;
	logic                       idx_start;
	logic                       gain_start;
	logic                       scale_start;
	logic                       load_out;
	logic                       cfg_we;
	logic                       out_free;
	tam_sts_t                   per_sts;
	tam_sts_t                   idx_sts;
	tam_sts_t                   gain_sts;
	tam_sts_t                   scale_sts;
	logic [PERIOD_W-1:0]        period;
	logic [TBL_AW-1:0]          index;
	logic [GAIN_W-1:0]          gain;
	logic signed [SAMPLE_W-1:0] result;
	logic [PHASE_W-1:0]         phase_eff;
	logic [CHAN_W-1:0]          chans_eff;
	logic                       frame_end;

	assign cfg_ready  = 1'b1;
	assign cfg_we     = cfg_valid && cfg_ready;
	assign src_stall  = state_q != ST_IDLE;
	assign dst_valid  = dst_valid_q;
	assign sample_out = out_q;
	assign out_free   = !dst_valid_q || !dst_stall;

	assign phase_eff = ({1'b0, phase_q} >= period) ? '0 : phase_q;

	always_comb begin
		if (chans_q == '0) begin
			chans_eff = CHAN_W'(1);
		end else if (chans_q > CHAN_MAX) begin
			chans_eff = CHAN_MAX;
		end else begin
			chans_eff = chans_q;
		end
	end

	assign frame_end = ({1'b0, chan_idx_q} + CHAN_W'(1)) >= chans_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		per_start   = 1'b0;
		idx_start   = 1'b0;
		gain_start  = 1'b0;
		scale_start = 1'b0;
		load_out    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (src_valid) begin
					per_start = period_dirty_q;
					state_d   = period_dirty_q ? ST_PERIOD : ST_PREP;
				end
			end
			ST_PERIOD: begin
				if (per_sts.done) begin
					state_d = ST_PREP;
				end
			end
			ST_PREP: begin
				idx_start = 1'b1;
				state_d   = ST_INDEX;
			end
			ST_INDEX: begin
				if (idx_sts.done) begin
					gain_start = 1'b1;
					state_d    = ST_GAIN;
				end
			end
			ST_GAIN: begin
				if (gain_sts.done) begin
					scale_start = 1'b1;
					state_d     = ST_SCALE;
				end
			end
			ST_SCALE: begin
				if (scale_sts.done) begin
					load_out = out_free;
					state_d  = out_free ? ST_IDLE : ST_HOLD;
				end
			end
			ST_HOLD: begin
				if (out_free) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q        <= DEPTH_RST;
			pms_q          <= PMS_RST;
			srate_q        <= SRATE_RST;
			chans_q        <= CHAN_RST;
			period_dirty_q <= 1'b1;
		end else begin
			if (per_start) begin
				period_dirty_q <= 1'b0;
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_DEPTH: begin
						depth_q <= cfg_data[DEPTH_W-1:0];
					end
					CFG_PERIOD_MS: begin
						pms_q          <= cfg_data[PMS_W-1:0];
						period_dirty_q <= 1'b1;
					end
					CFG_SAMPLE_RATE: begin
						srate_q        <= cfg_data[SRATE_W-1:0];
						period_dirty_q <= 1'b1;
					end
					CFG_CHANNELS: begin
						chans_q <= cfg_data[CHAN_W-1:0];
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= '0;
			chan_idx_q <= '0;
		end else if (idx_start) begin
			if (frame_end) begin
				chan_idx_q <= '0;
				phase_q    <= phase_eff + 1'b1;
			end else begin
				chan_idx_q <= chan_idx_q + 1'b1;
				phase_q    <= phase_eff;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (src_valid && !src_stall) begin
			sample_q <= sample_in;
		end
		if (load_out) begin
			out_q <= result;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dst_valid_q <= 1'b0;
		end else if (load_out) begin
			dst_valid_q <= 1'b1;
		end else if (!dst_stall) begin
			dst_valid_q <= 1'b0;
		end
	end

	tam_period u_period (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (per_start),
		.period_ms   (pms_q),
		.sample_rate (srate_q),
		.sts         (per_sts),
		.period      (period)
	);

	tam_index u_index (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (idx_start),
		.phase  (phase_eff),
		.period (period),
		.sts    (idx_sts),
		.index  (index)
	);

	tam_gain u_gain (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (gain_start),
		.index  (index),
		.depth  (depth_q),
		.sts    (gain_sts),
		.gain   (gain)
	);

	tam_scale u_scale (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (scale_start),
		.sample (sample_q),
		.gain   (gain),
		.sts    (scale_sts),
		.result (result)
	);

	a_one_unit: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({per_sts.busy, idx_sts.busy, gain_sts.busy, scale_sts.busy}))
		else $error("more than one arithmetic unit busy");

	a_scale_done: assert property (@(posedge clk) disable iff (!arst_n)
		scale_sts.done |-> state_q == ST_SCALE)
		else $error("scaled item outside the scale step");

	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && !period_dirty_q) |-> {1'b0, phase_q} <= period)
		else $error("frame phase beyond period");

endmodule
